// File: hdl/bppa_pkg.sv
// ----------------------------------------------------------------------------
// Binary pixel processor array package
// Grid size, cell layout, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package bppa_pkg;

	localparam int GRID_ROWS = 32;
	localparam int GRID_COLS = 32;
	localparam int CELL_W    = 14;
	localparam int MASK_IDX  = 13;
	localparam int ROW_AW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int COL_AW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	// Wide enough for any row or column index plus the grid size itself.
	localparam int IDX_W     = 9;

	typedef logic [CELL_W-1:0] cell_t;
	typedef cell_t [GRID_COLS-1:0] row_t;

	localparam cell_t CELL_RESET = cell_t'(1) << MASK_IDX;

	typedef enum logic [3:0] {
		OP_MOV     = 4'd0,
		OP_NORTH   = 4'd1,
		OP_EAST    = 4'd2,
		OP_SOUTH   = 4'd3,
		OP_WEST    = 4'd4,
		OP_NOT     = 4'd5,
		OP_NOR     = 4'd6,
		OP_WHERE   = 4'd7,
		OP_ALL     = 4'd8,
		OP_SET     = 4'd9,
		OP_PATTERN = 4'd10,
		OP_READ    = 4'd11
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_SWEEP,
		ST_READ
	} state_t;

	// Register bit of a cell; indices past the mask read as zero.
	function automatic logic reg_bit(input cell_t word, input logic [3:0] idx);
		logic b;
		b = 1'b0;
		if (idx <= 4'(MASK_IDX)) begin
			b = word[idx];
		end
		return b;
	endfunction

endpackage

// File: hdl/bppa_req_if.sv
// ----------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel that carries one instruction per beat.
// ----------------------------------------------------------------------------
interface bppa_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] req_type;
	logic [3:0] dst_reg;
	logic [3:0] src_a_reg;
	logic [3:0] src_b_reg;
	logic [4:0] row_or_fill;
	logic [4:0] col_sel;
	logic [4:0] row_ignore;
	logic [4:0] col_ignore;

	modport source (
		output valid, req_type, dst_reg, src_a_reg, src_b_reg,
		output row_or_fill, col_sel, row_ignore, col_ignore,
		input  ready
	);
	modport sink (
		input  valid, req_type, dst_reg, src_a_reg, src_b_reg,
		input  row_or_fill, col_sel, row_ignore, col_ignore,
		output ready
	);
endinterface

// File: hdl/bppa_rsp_if.sv
// ----------------------------------------------------------------------------
// Pixel read-back channel
// Valid/ready channel that carries one pixel word per beat.
// ----------------------------------------------------------------------------
interface bppa_rsp_if;
	logic        valid;
	logic        ready;
	logic [13:0] pixel_bits;

	modport source (output valid, pixel_bits, input ready);
	modport sink (input valid, pixel_bits, output ready);
endinterface

// File: hdl/binary_pixel_processor_array.sv
// ----------------------------------------------------------------------------
// Binary pixel processor array
// Grid of one-bit cell registers stored one grid row per memory word.
// ----------------------------------------------------------------------------
// Usage: instructions arrive on req, one per beat; only READ gives a beat on
// rsp, carrying the addressed cell's thirteen registers and its mask bit.
// A grid instruction sweeps the row memory once: a row is read ahead of its
// write-back, and the row above and the row itself are kept in registers so
// that every cell sees the grid as it was before the instruction. A READ
// passes through the registered row read and ST_READ before it loads the rsp
// register; unused opcodes are accepted and dropped. req is ready whenever
// the sweeper is idle, so non-READ instructions go on while a READ result
// waits on a stalled rsp; the next READ holds until the rsp register is free.
// Reset clears the sequencer and the per-row valid bits at once; a row that
// was never written reads as all registers zero with the mask set, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_pixel_processor_array (
	input logic       clk,
	input logic       arst_n,
	bppa_req_if.sink  req,
	bppa_rsp_if.source rsp
);
	import bppa_pkg::*;

	row_t                mem [GRID_ROWS];
	row_t                rd_data_s1;
	logic                rd_valid_s1;
	logic [GRID_ROWS-1:0] row_valid_q;

	state_t              state_q, state_d;
	logic [ROW_AW-1:0]   row_q;
	row_t                prev_q, cur_q;
	logic [3:0]          op_q, dst_q, sa_q, sb_q;
	logic [4:0]          rf_q, cs_q, ri_q, ci_q;
	logic                rd_oor_q;
	logic                out_valid_q;
	cell_t               out_data_q;

	logic                rd_en, we, load_out, in_range;
	logic [ROW_AW-1:0]   rd_addr;
	logic [ROW_AW:0]     row_p2;
	logic [IDX_W-1:0]    rf_ext, cs_ext;
	row_t                eff_row, new_row;
	logic                has_next;

	assign eff_row  = rd_valid_s1 ? rd_data_s1 : {GRID_COLS{CELL_RESET}};
	assign has_next = (row_q != ROW_AW'(GRID_ROWS - 1));
	assign row_p2   = {1'b0, row_q} + (ROW_AW + 1)'(2);
	assign rf_ext   = IDX_W'(req.row_or_fill);
	assign cs_ext   = IDX_W'(req.col_sel);
	assign in_range = (rf_ext < IDX_W'(GRID_ROWS)) && (cs_ext < IDX_W'(GRID_COLS));

	// Row memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[row_q] <= new_row;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (we) begin
				row_valid_q[row_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= row_valid_q[rd_addr];
			end
		end
	end

	// New value of the row being written, from the row above, the row itself
	// and the row below, all as they stood before the instruction.
	always_comb begin
		cell_t            s;
		logic             v, m, masked, north, south, east, west, pr, pc;
		logic [IDX_W-1:0] r_ext, c_ext, ri_n, ci_n;
		r_ext = IDX_W'(row_q);
		ri_n  = ~IDX_W'(ri_q);
		ci_n  = ~IDX_W'(ci_q);
		pr    = ((r_ext & ri_n) == (IDX_W'(rf_q) & ri_n));
		for (int c = 0; c < GRID_COLS; c++) begin
			s      = cur_q[c];
			m      = s[MASK_IDX];
			masked = 1'b1;
			v      = 1'b0;
			c_ext  = IDX_W'(c);
			pc     = ((c_ext & ci_n) == (IDX_W'(cs_q) & ci_n));
			north  = reg_bit(prev_q[c], sa_q);
			south  = has_next ? reg_bit(eff_row[c], sa_q) : 1'b0;
			east   = (c < GRID_COLS - 1) ? reg_bit(cur_q[(c + 1) % GRID_COLS], sa_q) : 1'b0;
			west   = (c > 0) ? reg_bit(cur_q[(c + GRID_COLS - 1) % GRID_COLS], sa_q)
				: 1'b0;
			case (op_q)
				OP_MOV:   v = reg_bit(s, sa_q);
				OP_NORTH: v = north;
				OP_EAST:  v = east;
				OP_SOUTH: v = south;
				OP_WEST:  v = west;
				OP_NOT:   v = ~reg_bit(s, sa_q);
				OP_NOR:   v = ~(reg_bit(s, sa_q) | reg_bit(s, sb_q));
				OP_SET:   v = (rf_q != 5'd0);
				default: begin
					masked = 1'b0;
					v      = pr && pc;
				end
			endcase
			if (op_q == OP_WHERE) begin
				s[MASK_IDX] = reg_bit(cur_q[c], dst_q);
			end else if (op_q == OP_ALL) begin
				s[MASK_IDX] = 1'b1;
			end else if ((dst_q <= 4'(MASK_IDX)) && (!masked || m)) begin
				s[dst_q] = v;
			end
			new_row[c] = s;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		we        = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.req_type == OP_READ) begin
						rd_en   = in_range;
						rd_addr = rf_ext[ROW_AW-1:0];
						state_d = ST_READ;
					end else if (req.req_type <= OP_PATTERN) begin
						rd_en   = 1'b1;
						state_d = ST_PRIME;
					end
				end
			end
			ST_PRIME: begin
				rd_en   = 1'b1;
				rd_addr = ROW_AW'(1);
				state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				we = 1'b1;
				if (row_p2 < (ROW_AW + 1)'(GRID_ROWS)) begin
					rd_en   = 1'b1;
					rd_addr = row_p2[ROW_AW-1:0];
				end
				if (!has_next) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q     <= req.req_type;
			dst_q    <= req.dst_reg;
			sa_q     <= req.src_a_reg;
			sb_q     <= req.src_b_reg;
			rf_q     <= req.row_or_fill;
			cs_q     <= req.col_sel;
			ri_q     <= req.row_ignore;
			ci_q     <= req.col_ignore;
			rd_oor_q <= !in_range;
		end
		if (state_q == ST_PRIME) begin
			prev_q <= '0;
			cur_q  <= eff_row;
			row_q  <= '0;
		end else if (state_q == ST_SWEEP) begin
			prev_q <= cur_q;
			cur_q  <= eff_row;
			row_q  <= row_q + ROW_AW'(1);
		end
		if (load_out) begin
			out_data_q <= rd_oor_q ? '0 : eff_row[COL_AW'(IDX_W'(cs_q))];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.pixel_bits = out_data_q;

endmodule
